// ===== sv/vsids_literal_activity_ranker_defines.svh =====
// Assertion macros shared by the literal activity ranker modules.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef VSIDS_LITERAL_ACTIVITY_RANKER_DEFINES_SVH
`define VSIDS_LITERAL_ACTIVITY_RANKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VLAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define VLAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vlar_pkg.sv =====
// Package of the literal activity ranker: sizes, codes, controller states,
// datapath operations and the command and status structs. No dependencies.
package vlar_pkg;

    localparam int MAX_VARS   = 1024;
    localparam int ADDR_W     = $clog2(MAX_VARS);
    localparam int VAR_W      = 11;
    localparam int RANK_W     = 10;
    localparam int CFG_DATA_W = 16;
    localparam int SCORE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = SCORE_BITS + CFG_DATA_W;

    localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;
    localparam logic [SCORE_BITS-1:0] SCORE_ONE = SCORE_BITS'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        CMD_INIT_LIT  = 2'd0,
        CMD_LEARN_LIT = 2'd1,
        CMD_POLARITY  = 2'd2,
        CMD_RANK_READ = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        CFG_VARS_IN_USE  = 2'd0,
        CFG_DECAY_FACTOR = 2'd1,
        CFG_DECAY_PERIOD = 2'd2
    } t_cfg_index;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_ITEM_RD, S_ITEM_EX,
        S_DEC_RD, S_DEC_MP, S_DEC_MN, S_DEC_WN,
        S_KEY_RD, S_KEY_VR, S_KEY_WR,
        S_SORT_RD, S_SORT_LD, S_STEP_RD, S_STEP_CMP, S_SORT_PUT,
        S_FINISH
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_ACCEPT, OP_ITEM_RD, OP_ITEM_EX,
        OP_DEC_RD, OP_DEC_MP, OP_DEC_MN, OP_DEC_WN,
        OP_KEY_RD, OP_KEY_VR, OP_KEY_WR,
        OP_SORT_RD, OP_SORT_LD, OP_STEP_RD, OP_STEP_CMP, OP_SORT_PUT,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_dp_cmd;

    typedef struct packed {
        logic is_lit_last;
        logic decay_hit;
        logic sort_needed;
        logic idx_last_all;
        logic idx_last_key;
        logic key_less;
        logic j_one;
        logic j_zero;
        logic i_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== sv/vlar_ram.sv =====
// Generic single-port RAM with registered read data (read-before-write).
// No dependencies.
module vlar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/vlar_ctrl.sv =====
// Controller state machine of the literal activity ranker.
// Depends on vlar_pkg and the assertion macro header.
`include "vsids_literal_activity_ranker_defines.svh"

module vlar_ctrl import vlar_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (i_sts.idx_last_all) n_state = S_IDLE;
            S_IDLE:     if (i_in_valid) n_state = S_ITEM_RD;
            S_ITEM_RD:  n_state = S_ITEM_EX;
            S_ITEM_EX: begin
                if (!i_sts.is_lit_last) n_state = S_FINISH;
                else if (i_sts.decay_hit) n_state = S_DEC_RD;
                else if (i_sts.sort_needed) n_state = S_KEY_RD;
                else n_state = S_FINISH;
            end
            S_DEC_RD:   n_state = S_DEC_MP;
            S_DEC_MP:   n_state = S_DEC_MN;
            S_DEC_MN:   n_state = S_DEC_WN;
            S_DEC_WN: begin
                if (!i_sts.idx_last_all) n_state = S_DEC_RD;
                else if (i_sts.sort_needed) n_state = S_KEY_RD;
                else n_state = S_FINISH;
            end
            S_KEY_RD:   n_state = S_KEY_VR;
            S_KEY_VR:   n_state = S_KEY_WR;
            S_KEY_WR:   n_state = i_sts.idx_last_key ? S_SORT_RD : S_KEY_RD;
            S_SORT_RD:  n_state = S_SORT_LD;
            S_SORT_LD:  n_state = S_STEP_RD;
            S_STEP_RD:  n_state = S_STEP_CMP;
            S_STEP_CMP: n_state = (i_sts.key_less && !i_sts.j_one) ? S_STEP_RD : S_SORT_PUT;
            S_SORT_PUT: n_state = i_sts.i_last ? S_FINISH : S_SORT_RD;
            S_FINISH:   if (i_sts.out_free) n_state = S_IDLE;
            default:    n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '{op: OP_NONE, in_ready: 1'b0};
        unique case (r_state)
            S_CLEAR: o_cmd.op = OP_CLEAR;
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.op       = i_in_valid ? OP_ACCEPT : OP_NONE;
            end
            S_ITEM_RD:  o_cmd.op = OP_ITEM_RD;
            S_ITEM_EX:  o_cmd.op = OP_ITEM_EX;
            S_DEC_RD:   o_cmd.op = OP_DEC_RD;
            S_DEC_MP:   o_cmd.op = OP_DEC_MP;
            S_DEC_MN:   o_cmd.op = OP_DEC_MN;
            S_DEC_WN:   o_cmd.op = OP_DEC_WN;
            S_KEY_RD:   o_cmd.op = OP_KEY_RD;
            S_KEY_VR:   o_cmd.op = OP_KEY_VR;
            S_KEY_WR:   o_cmd.op = OP_KEY_WR;
            S_SORT_RD:  o_cmd.op = OP_SORT_RD;
            S_SORT_LD:  o_cmd.op = OP_SORT_LD;
            S_STEP_RD:  o_cmd.op = OP_STEP_RD;
            S_STEP_CMP: o_cmd.op = OP_STEP_CMP;
            S_SORT_PUT: o_cmd.op = OP_SORT_PUT;
            S_FINISH:   o_cmd.op = i_sts.out_free ? OP_FINISH : OP_NONE;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    `VLAR_ASSERT_NEXT(a_accept_reads, i_in_valid && o_cmd.in_ready, r_state == S_ITEM_RD,
        "accepted transaction did not start its read")
    `VLAR_ASSERT_NEXT(a_finish_holds, r_state == S_FINISH && !i_sts.out_free,
        r_state == S_FINISH, "result left while output register was full")
    `VLAR_ASSERT_NOW(a_step_j_nonzero, r_state == S_STEP_RD, !i_sts.j_zero,
        "insertion step read below rank zero")

endmodule

// ===== sv/vlar_dp.sv =====
// Datapath of the literal activity ranker: configuration registers, item and
// result registers, sweep counters, decay multiplier and the four RAMs.
// Depends on vlar_pkg, vlar_ram and the assertion macro header.
`include "vsids_literal_activity_ranker_defines.svh"

module vlar_dp import vlar_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [1:0]            i_cmd_code,
    input  logic [VAR_W-1:0]      i_var_index,
    input  logic                  i_negated,
    input  logic                  i_clause_last,
    input  logic [RANK_W-1:0]     i_rank,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_prefer_true,
    output logic [VAR_W-1:0]      o_ranked_var,
    output logic                  o_saturated
);

    logic [VAR_W-1:0]      r_vars_in_use;
    logic [CFG_DATA_W-1:0] r_decay_factor;
    logic [CFG_DATA_W-1:0] r_decay_period;
    logic [CFG_DATA_W-1:0] r_learned_count;

    logic [1:0]        r_cmd;
    logic [VAR_W-1:0]  r_var;
    logic              r_neg;
    logic              r_last;
    logic [RANK_W-1:0] r_rank;

    logic [ADDR_W-1:0]     r_idx;
    logic [ADDR_W-1:0]     r_i;
    logic [ADDR_W-1:0]     r_j;
    logic [VAR_W-1:0]      r_v;
    logic [SCORE_BITS-1:0] r_k;
    logic [PROD_W-1:0]     r_prod;

    logic              r_res_prefer;
    logic [VAR_W-1:0]  r_res_ranked;
    logic              r_res_sat;
    logic              r_out_valid;
    logic              r_out_prefer;
    logic [VAR_W-1:0]  r_out_ranked;
    logic              r_out_sat;

    logic [ADDR_W-1:0]     score_addr;
    logic                  pos_we;
    logic                  neg_we;
    logic [SCORE_BITS-1:0] score_wdata;
    logic [SCORE_BITS-1:0] pos_rdata;
    logic [SCORE_BITS-1:0] neg_rdata;
    logic [ADDR_W-1:0]     rank_addr;
    logic                  rank_we;
    logic [VAR_W-1:0]      rank_wdata;
    logic [VAR_W-1:0]      rank_rdata;
    logic                  key_we;
    logic [SCORE_BITS-1:0] key_wdata;
    logic [SCORE_BITS-1:0] key_rdata;

    logic [VAR_W-1:0]      active;
    logic                  var_ok;
    logic [ADDR_W-1:0]     var_addr;
    logic                  is_lit;
    logic [SCORE_BITS-1:0] bump_src;
    logic                  bump_sat;
    logic [SCORE_BITS-1:0] bump_val;
    logic [CFG_DATA_W-1:0] count_inc;
    logic                  decay_hit;
    logic [SCORE_BITS-1:0] mul_a;
    logic [SCORE_BITS-1:0] decayed;
    logic                  key_less;

    assign active   = (r_vars_in_use > VAR_W'(MAX_VARS)) ? VAR_W'(MAX_VARS) : r_vars_in_use;
    assign var_ok   = (r_var != '0) && (r_var <= VAR_W'(MAX_VARS));
    assign var_addr = ADDR_W'(r_var - VAR_W'(1));
    assign is_lit   = (r_cmd == CMD_INIT_LIT) || (r_cmd == CMD_LEARN_LIT);
    assign bump_src = r_neg ? neg_rdata : pos_rdata;
    assign bump_sat = bump_src >= (SCORE_MAX - SCORE_ONE);
    assign bump_val = bump_sat ? SCORE_MAX : bump_src + SCORE_ONE;
    assign count_inc = r_learned_count + CFG_DATA_W'(1);
    assign decay_hit = (r_cmd == CMD_LEARN_LIT) && r_last && (r_decay_period != '0)
                       && (count_inc == r_decay_period);
    assign mul_a    = (i_cmd.op == OP_DEC_MP) ? pos_rdata : r_k;
    assign decayed  = r_prod[FRAC_BITS +: SCORE_BITS];
    assign key_less = key_rdata < r_k;

    always_comb begin
        o_sts.is_lit_last  = is_lit && r_last;
        o_sts.decay_hit    = decay_hit;
        o_sts.sort_needed  = active > VAR_W'(1);
        o_sts.idx_last_all = r_idx == ADDR_W'(MAX_VARS - 1);
        o_sts.idx_last_key = {1'b0, r_idx} == active - VAR_W'(1);
        o_sts.key_less     = key_less;
        o_sts.j_one        = r_j == ADDR_W'(1);
        o_sts.j_zero       = r_j == '0;
        o_sts.i_last       = {1'b0, r_i} == active - VAR_W'(1);
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

    // Memory port steering.
    always_comb begin
        score_addr  = r_idx;
        pos_we      = 1'b0;
        neg_we      = 1'b0;
        score_wdata = decayed;
        rank_addr   = r_idx;
        rank_we     = 1'b0;
        rank_wdata  = rank_rdata;
        key_we      = 1'b0;
        key_wdata   = key_rdata;
        case (i_cmd.op)
            OP_CLEAR: begin
                pos_we      = 1'b1;
                neg_we      = 1'b1;
                score_wdata = '0;
                rank_we     = 1'b1;
                rank_wdata  = {1'b0, r_idx} + VAR_W'(1);
            end
            OP_ITEM_RD: begin
                score_addr = var_addr;
                rank_addr  = r_rank;
            end
            OP_ITEM_EX: begin
                score_addr  = var_addr;
                score_wdata = bump_val;
                pos_we      = is_lit && var_ok && !r_neg;
                neg_we      = is_lit && var_ok && r_neg;
            end
            OP_DEC_MN: pos_we = 1'b1;
            OP_DEC_WN: neg_we = 1'b1;
            OP_KEY_VR: score_addr = ADDR_W'(rank_rdata - VAR_W'(1));
            OP_KEY_WR: begin
                key_we    = 1'b1;
                key_wdata = (pos_rdata > neg_rdata) ? pos_rdata : neg_rdata;
            end
            OP_SORT_RD: rank_addr = r_i;
            OP_STEP_RD: rank_addr = r_j - ADDR_W'(1);
            OP_STEP_CMP: begin
                rank_addr = r_j;
                rank_we   = key_less;
                key_we    = key_less;
            end
            OP_SORT_PUT: begin
                rank_addr  = r_j;
                rank_we    = 1'b1;
                rank_wdata = r_v;
                key_we     = 1'b1;
                key_wdata  = r_k;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vars_in_use   <= VAR_W'(MAX_VARS);
            r_decay_factor  <= CFG_DATA_W'(32768);
            r_decay_period  <= CFG_DATA_W'(256);
            r_learned_count <= '0;
            r_idx           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_VARS_IN_USE:  r_vars_in_use  <= i_cfg_data[VAR_W-1:0];
                    CFG_DECAY_FACTOR: r_decay_factor <= i_cfg_data;
                    CFG_DECAY_PERIOD: r_decay_period <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_ITEM_EX && is_lit && r_last && r_cmd == CMD_LEARN_LIT) begin
                r_learned_count <= decay_hit ? '0 : count_inc;
            end
            case (i_cmd.op) inside
                OP_CLEAR, OP_DEC_WN, OP_KEY_WR: r_idx <= r_idx + ADDR_W'(1);
                OP_ITEM_EX: r_idx <= '0;
                default: ;
            endcase
            if (i_cmd.op == OP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_cmd  <= i_cmd_code;
                r_var  <= i_var_index;
                r_neg  <= i_negated;
                r_last <= i_clause_last;
                r_rank <= i_rank;
            end
            OP_ITEM_EX: begin
                r_i          <= ADDR_W'(1);
                r_res_prefer <= (r_cmd == CMD_POLARITY) && var_ok && (pos_rdata > neg_rdata);
                r_res_sat    <= is_lit && var_ok && bump_sat;
                r_res_ranked <= ((r_cmd == CMD_RANK_READ) && ({1'b0, r_rank} < active))
                                ? rank_rdata : '0;
            end
            OP_DEC_MP: begin
                r_prod <= mul_a * r_decay_factor;
                r_k    <= neg_rdata;
            end
            OP_DEC_MN: r_prod <= mul_a * r_decay_factor;
            OP_SORT_LD: begin
                r_v <= rank_rdata;
                r_k <= key_rdata;
                r_j <= r_i;
            end
            OP_STEP_CMP: if (key_less) r_j <= r_j - ADDR_W'(1);
            OP_SORT_PUT: r_i <= r_i + ADDR_W'(1);
            OP_FINISH: begin
                r_out_prefer <= r_res_prefer;
                r_out_ranked <= r_res_ranked;
                r_out_sat    <= r_res_sat;
            end
            default: ;
        endcase
    end

    vlar_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_VARS)) u_pos_ram (
        .i_clk(i_clk), .i_we(pos_we), .i_addr(score_addr),
        .i_wdata(score_wdata), .o_rdata(pos_rdata)
    );
    vlar_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_VARS)) u_neg_ram (
        .i_clk(i_clk), .i_we(neg_we), .i_addr(score_addr),
        .i_wdata(score_wdata), .o_rdata(neg_rdata)
    );
    vlar_ram #(.WIDTH(VAR_W), .DEPTH(MAX_VARS)) u_rank_ram (
        .i_clk(i_clk), .i_we(rank_we), .i_addr(rank_addr),
        .i_wdata(rank_wdata), .o_rdata(rank_rdata)
    );
    vlar_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_VARS)) u_key_ram (
        .i_clk(i_clk), .i_we(key_we), .i_addr(rank_addr),
        .i_wdata(key_wdata), .o_rdata(key_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_prefer_true = r_out_prefer;
    assign o_ranked_var  = r_out_ranked;
    assign o_saturated   = r_out_sat;

    `VLAR_ASSERT_NOW(a_decay_needs_period, i_cmd.op == OP_DEC_RD, r_decay_period != '0,
        "decay sweep started with a zero period")

endmodule

// ===== sv/vsids_literal_activity_ranker.sv =====
// Top level of the literal activity ranker: controller plus datapath.
// Depends on vlar_pkg, vlar_ctrl and vlar_dp.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------------------
//   in      | to block  | i_valid / o_ready       | i_cmd, i_var_index, i_negated,
//           |           |                         | i_clause_last, i_rank
//   out     | from block| o_valid / i_ready       | o_prefer_true, o_ranked_var,
//           |           |                         | o_saturated
//   cfg     | to block  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// After reset a clearing pass zeroes the score RAMs and loads the identity
// order; no input transaction is taken during it.
// A bump or query passes the item read and item execute states and reaches the
// output register in the finish state, which waits while that register holds an
// unread result; input is then taken again from idle. A literal clause end adds a
// key refresh over the n ranks in use and an insertion sort (n = effective
// vars_in_use) on the single-port rank and key RAMs, both skipped when n is one or
// less; a decay adds a sweep over all 1024 entries through the shared multiplier.
// One item is in flight at a time; a result waiting in the output register
// does not block acceptance, only the completion of the next item.
// Configuration transactions are always taken and apply at once.
module vsids_literal_activity_ranker import vlar_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_cmd,
    input  logic [VAR_W-1:0]      i_var_index,
    input  logic                  i_negated,
    input  logic                  i_clause_last,
    input  logic [RANK_W-1:0]     i_rank,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_prefer_true,
    output logic [VAR_W-1:0]      o_ranked_var,
    output logic                  o_saturated,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // The controller sequences every item; the datapath owns all storage.
    vlar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    vlar_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_cmd_code    (i_cmd),
        .i_var_index   (i_var_index),
        .i_negated     (i_negated),
        .i_clause_last (i_clause_last),
        .i_rank        (i_rank),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_prefer_true (o_prefer_true),
        .o_ranked_var  (o_ranked_var),
        .o_saturated   (o_saturated)
    );

    // Input is taken only while the controller sits idle.
    assign o_ready     = dp_cmd.in_ready;
    // Configuration registers are plain flops and accept a write every cycle.
    assign o_cfg_ready = 1'b1;

endmodule

// ===== sim/vsids_literal_activity_ranker_tb.sv =====
// Self-checking testbench for vsids_literal_activity_ranker: directed and random
// literal, query and register traffic against a behavioral score and rank model.
// Depends on vlar_pkg and the ranker RTL only.
module vsids_literal_activity_ranker_tb;
    import vlar_pkg::*;

    // The result of one command, as the block should report it.
    typedef struct {
        logic             prefer_true;
        logic [VAR_W-1:0] ranked_var;
        logic             saturated;
    } t_answer;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [1:0]            i_cmd;
    logic [VAR_W-1:0]      i_var_index;
    logic                  i_negated;
    logic                  i_clause_last;
    logic [RANK_W-1:0]     i_rank;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_prefer_true;
    logic [VAR_W-1:0]      o_ranked_var;
    logic                  o_saturated;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    vsids_literal_activity_ranker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_var_index   (i_var_index),
        .i_negated     (i_negated),
        .i_clause_last (i_clause_last),
        .i_rank        (i_rank),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_prefer_true (o_prefer_true),
        .o_ranked_var  (o_ranked_var),
        .o_saturated   (o_saturated),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Model state: one score per literal, the variable order, the learned
    // clause counter and the three registers.
    logic [SCORE_BITS-1:0] pos_score [MAX_VARS];
    logic [SCORE_BITS-1:0] neg_score [MAX_VARS];
    logic [VAR_W-1:0]      var_order [MAX_VARS];
    logic [15:0]           learned_clauses;
    logic [VAR_W-1:0]      reg_vars_in_use;
    logic [15:0]           reg_decay_factor;
    logic [15:0]           reg_decay_period;

    t_answer pending_answers [$];
    int      fail_count;
    int      burst_left;
    // When set, the sender never pauses between transactions.
    bit      back_to_back;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // One line per mismatch; the run carries on to its normal end.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic int active_vars();
        return (reg_vars_in_use > MAX_VARS) ? MAX_VARS : int'(reg_vars_in_use);
    endfunction

    // The sort key of a variable is the larger of its two literal scores.
    function automatic logic [SCORE_BITS-1:0] activity_of(input logic [VAR_W-1:0] v);
        int idx;
        idx = (v >= 1 && v <= MAX_VARS) ? int'(v) - 1 : 0;
        return (pos_score[idx] > neg_score[idx]) ? pos_score[idx] : neg_score[idx];
    endfunction

    // Stable descending insertion sort over the ranks in use.
    task automatic resort_order();
        logic [VAR_W-1:0]      moving;
        logic [SCORE_BITS-1:0] key;
        int j;
        for (int i = 1; i < active_vars(); i++) begin
            moving = var_order[i];
            key = activity_of(moving);
            j = i;
            while (j > 0 && activity_of(var_order[j-1]) < key) begin
                var_order[j] = var_order[j-1];
                j--;
            end
            var_order[j] = moving;
        end
    endtask

    task automatic decay_scores();
        logic [PROD_W-1:0] prod;
        for (int i = 0; i < MAX_VARS; i++) begin
            prod = PROD_W'(pos_score[i]) * PROD_W'(reg_decay_factor);
            pos_score[i] = prod[FRAC_BITS +: SCORE_BITS];
            prod = PROD_W'(neg_score[i]) * PROD_W'(reg_decay_factor);
            neg_score[i] = prod[FRAC_BITS +: SCORE_BITS];
        end
    endtask

    // Bumps a literal score by 1.0, pinning it at the ceiling.
    function automatic logic bump_score(inout logic [SCORE_BITS-1:0] s);
        if (SCORE_MAX - s <= SCORE_ONE) begin
            s = SCORE_MAX;
            return 1'b1;
        end
        s = s + SCORE_ONE;
        return 1'b0;
    endfunction

    // Applies one accepted command to the model and returns its result.
    task automatic predict_answer(input t_cmd_code cmd, input logic [VAR_W-1:0] v,
                                  input logic neg, input logic last,
                                  input logic [RANK_W-1:0] rank, output t_answer ans);
        logic known;
        known = (v >= 1 && v <= MAX_VARS);
        ans = '{1'b0, '0, 1'b0};
        case (cmd) inside
            CMD_INIT_LIT, CMD_LEARN_LIT: begin
                if (known) begin
                    if (neg) ans.saturated = bump_score(neg_score[v-1]);
                    else     ans.saturated = bump_score(pos_score[v-1]);
                end
                if (last) begin
                    if (cmd == CMD_LEARN_LIT) begin
                        learned_clauses = learned_clauses + 16'd1;
                        if (reg_decay_period != 0 && learned_clauses == reg_decay_period) begin
                            decay_scores();
                            learned_clauses = '0;
                        end
                    end
                    resort_order();
                end
            end
            CMD_POLARITY: begin
                ans.prefer_true = known && (pos_score[v-1] > neg_score[v-1]);
            end
            default: begin
                if (rank < active_vars()) ans.ranked_var = var_order[rank];
            end
        endcase
    endtask

    // Sends one transaction; outside back-to-back mode, bursts of random length are mostly separated by random gaps.
    task automatic send_item(input t_cmd_code cmd, input logic [VAR_W-1:0] v,
                             input logic neg, input logic last, input logic [RANK_W-1:0] rank);
        t_answer ans;
        if (!back_to_back && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                i_valid = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        i_valid       = 1'b1;
        i_cmd         = cmd;
        i_var_index   = v;
        i_negated     = neg;
        i_clause_last = last;
        i_rank        = rank;
        do @(posedge i_clk); while (!o_ready);
        predict_answer(cmd, v, neg, last, rank, ans);
        pending_answers.insert(pending_answers.size(), ans);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Register writes happen only with nothing in flight.
    task automatic write_register(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        wait (pending_answers.size() == 0);
        repeat (8) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_VARS_IN_USE:  reg_vars_in_use  = data[VAR_W-1:0];
            CFG_DECAY_FACTOR: reg_decay_factor = data;
            default:          reg_decay_period = data;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Receiver: alternates between always ready, random stalls and long stalls.
    initial begin
        int mode;
        int left;
        i_ready = 1'b0;
        left = 0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 300);
            end
            left--;
            case (mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= ($urandom_range(0, 1) == 1);
                default: i_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Result checker: each transaction on the output channel against the oldest expectation.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_answers.pop_front();
                if (o_prefer_true !== want.prefer_true)
                    report_mismatch("prefer_true", o_prefer_true, want.prefer_true);
                if (o_ranked_var !== want.ranked_var)
                    report_mismatch("ranked_var", o_ranked_var, want.ranked_var);
                if (o_saturated !== want.saturated)
                    report_mismatch("saturated", o_saturated, want.saturated);
            end
        end
    end

    // Reset-state queries, both literal kinds, bad variables and clause ends at full size.
    task automatic test_directed();
        send_item(CMD_POLARITY, 11'd1, 1'b0, 1'b0, '0);
        send_item(CMD_RANK_READ, 11'd0, 1'b0, 1'b0, 10'd0);
        send_item(CMD_RANK_READ, 11'd0, 1'b0, 1'b0, 10'd1023);
        // A bad variable bumps nothing but its clause end still sorts.
        send_item(CMD_INIT_LIT, 11'd0, 1'b1, 1'b1, '0);
        send_item(CMD_LEARN_LIT, 11'd2047, 1'b0, 1'b1, 10'd1023);
        send_item(CMD_POLARITY, 11'd2047, 1'b1, 1'b0, '0);
        send_item(CMD_INIT_LIT, 11'd1024, 1'b1, 1'b0, '0);
        send_item(CMD_INIT_LIT, 11'd1024, 1'b1, 1'b0, '0);
        send_item(CMD_INIT_LIT, 11'd1, 1'b0, 1'b0, '0);
        send_item(CMD_INIT_LIT, 11'd1025, 1'b0, 1'b1, '0);
        send_item(CMD_LEARN_LIT, 11'd512, 1'b0, 1'b1, '0);
        // The clause end flag does nothing on queries.
        send_item(CMD_POLARITY, 11'd1024, 1'b0, 1'b1, '0);
        send_item(CMD_POLARITY, 11'd1, 1'b1, 1'b1, '0);
        send_item(CMD_POLARITY, 11'd512, 1'b0, 1'b0, '0);
        send_item(CMD_RANK_READ, 11'd0, 1'b0, 1'b1, 10'd0);
        send_item(CMD_RANK_READ, 11'd0, 1'b1, 1'b0, 10'd1);
        send_item(CMD_RANK_READ, 11'd0, 1'b0, 1'b0, 10'd2);
        send_item(CMD_RANK_READ, 11'd0, 1'b0, 1'b0, 10'd1023);
    endtask

    // Register extremes: no variables, oversize count, zero and full decay factors.
    task automatic test_register_extremes();
        write_register(CFG_VARS_IN_USE, 16'd0);
        send_item(CMD_INIT_LIT, 11'd3, 1'b0, 1'b1, '0);
        send_item(CMD_RANK_READ, 11'd0, 1'b0, 1'b0, 10'd0);
        write_register(CFG_VARS_IN_USE, 16'hFFFF);
        send_item(CMD_RANK_READ, 11'd0, 1'b0, 1'b0, 10'd1023);
        write_register(CFG_VARS_IN_USE, 16'd1);
        send_item(CMD_RANK_READ, 11'd0, 1'b0, 1'b0, 10'd1);
        write_register(CFG_VARS_IN_USE, 16'd6);
        write_register(CFG_DECAY_PERIOD, 16'd1);
        write_register(CFG_DECAY_FACTOR, 16'd0);
        send_item(CMD_LEARN_LIT, 11'd4, 1'b1, 1'b1, '0);
        send_item(CMD_POLARITY, 11'd1, 1'b0, 1'b0, '0);
        write_register(CFG_DECAY_FACTOR, 16'hFFFF);
        send_item(CMD_LEARN_LIT, 11'd5, 1'b0, 1'b0, '0);
        send_item(CMD_LEARN_LIT, 11'd5, 1'b0, 1'b1, '0);
        send_item(CMD_RANK_READ, 11'd0, 1'b0, 1'b0, 10'd0);
        write_register(CFG_DECAY_PERIOD, 16'hFFFF);
        send_item(CMD_LEARN_LIT, 11'd2, 1'b0, 1'b1, '0);
        write_register(CFG_DECAY_PERIOD, 16'd0);
        send_item(CMD_LEARN_LIT, 11'd3, 1'b1, 1'b1, '0);
        send_item(CMD_RANK_READ, 11'd0, 1'b0, 1'b0, 10'd5);
    endtask

    // Bumps one literal many times back to back; no clause end, so no sort cost.
    task automatic test_repeated_bumps();
        back_to_back = 1'b1;
        for (int k = 0; k < 150; k++)
            send_item(CMD_INIT_LIT, 11'd7, 1'b1, 1'b0, '0);
        send_item(CMD_POLARITY, 11'd7, 1'b0, 1'b0, '0);
        back_to_back = 1'b0;
    endtask

    // Random clauses with random content, queries in between and a little noise.
    task automatic test_random_traffic();
        int n;
        int len;
        int roll;
        logic [VAR_W-1:0] v;
        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 11) n = 1024;
            else if (phase % 4 == 0) n = $urandom_range(40, 120);
            else n = $urandom_range(2, 16);
            write_register(CFG_VARS_IN_USE, 16'(n));
            write_register(CFG_DECAY_FACTOR, 16'($urandom_range(0, 65535)));
            write_register(CFG_DECAY_PERIOD, ($urandom_range(0, 3) == 0) ? 16'd0
                                                : 16'($urandom_range(1, 5)));
            for (int c = 0; c < ((phase == 11) ? 8 : 80); c++) begin
                roll = $urandom_range(0, 9);
                if (roll < 6) begin
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++) begin
                        roll = $urandom_range(0, 19);
                        if (roll == 0) v = 11'($urandom_range(1025, 2047));
                        else if (roll == 1) v = '0;
                        else if (roll == 2) v = 11'($urandom_range(1, 1024));
                        else v = 11'($urandom_range(1, n + 2 > 1024 ? 1024 : n + 2));
                        send_item(($urandom_range(0, 1) == 1) ? CMD_LEARN_LIT : CMD_INIT_LIT,
                                  v, 1'($urandom_range(0, 1)),
                                  (k == len - 1) || ($urandom_range(0, 15) == 0), '0);
                    end
                end else if (roll < 8) begin
                    send_item(CMD_POLARITY, 11'($urandom_range(0, n + 1 > 2047 ? 2047 : n + 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), '0);
                end else begin
                    send_item(CMD_RANK_READ, 11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)),
                              ($urandom_range(0, 5) == 0) ? 10'($urandom_range(0, 1023))
                                                          : 10'($urandom_range(0, n)));
                end
            end
        end
    endtask

    initial begin
        fail_count = 0;
        burst_left = 0;
        back_to_back = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CMD_INIT_LIT;
        i_var_index = '0;
        i_negated = 1'b0;
        i_clause_last = 1'b0;
        i_rank = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_VARS_IN_USE;
        i_cfg_data = '0;
        for (int i = 0; i < MAX_VARS; i++) begin
            pos_score[i] = '0;
            neg_score[i] = '0;
            var_order[i] = VAR_W'(i + 1);
        end
        learned_clauses = '0;
        reg_vars_in_use = 11'd1024;
        reg_decay_factor = 16'd32768;
        reg_decay_period = 16'd256;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_register_extremes();
        test_repeated_bumps();
        test_random_traffic();

        // Drain: every result in, then a short settle.
        wait (pending_answers.size() == 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
